// ===== src/eau_pkg.sv =====
package eau_pkg;

	localparam logic [7:0] GRP_EAU0 = 8'o200;
	localparam logic [7:0] GRP_DIV  = 8'o201;
	localparam logic [7:0] GRP_EAU2 = 8'o202;

	localparam int QDEPTH = 2;
	localparam int DIV_STEPS = 16;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNDEF   = 2'd1,
		ST_UNIMPL  = 2'd2,
		ST_NOTHERE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		OP_PASS, OP_ASL, OP_LSL, OP_RRL, OP_ASR, OP_LSR, OP_RRR,
		OP_TIMER, OP_MPY, OP_DIV
	} op_t;

	typedef enum logic [1:0] {
		REG_INSTALLED = 2'd0,
		REG_MODEL     = 2'd1,
		REG_STOP_UNDEF = 2'd2,
		REG_STOP_UNIMPL = 2'd3
	} reg_idx_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t         op;
		logic [4:0]  sh;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] m;
		logic        ov;
		status_t     st;
	} cmd_t;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic        ov;
		logic        rep;
		status_t     st;
	} res_t;

endpackage

// ===== src/eau_if.sv =====
interface eau_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] instr_word;
	logic [15:0] a_in;
	logic [15:0] b_in;
	logic [15:0] mem_word;
	logic        overflow_in;
	modport source(output valid, instr_word, a_in, b_in, mem_word, overflow_in, input ready);
	modport sink(input valid, instr_word, a_in, b_in, mem_word, overflow_in, output ready);
endinterface

interface eau_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] a_out;
	logic [15:0] b_out;
	logic        overflow_out;
	logic        repeat_request;
	logic [1:0]  status;
	modport source(output valid, a_out, b_out, overflow_out, repeat_request, status, input ready);
	modport sink(input valid, a_out, b_out, overflow_out, repeat_request, status, output ready);
endinterface

interface eau_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [1:0]  data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/extended_arithmetic_unit.sv =====
// Path from input beat to result beat: classify queue, capture stage, 16 divide steps,
// fix-up and output stages; the same path for every operation.
// Throughput: one instruction per cycle; the in-order pipe stalls only on output backpressure.
// Reset (arst_n low) empties queue and pipe; config resets to installed, E/F model, no stops.
module extended_arithmetic_unit (
	input  logic      clk,
	input  logic      arst_n,
	eau_in_if.sink    in_ch,
	eau_cfg_if.sink   cfg,
	eau_out_if.source out_ch
);

	eau_pkg::cmd_t cmd;
	eau_pkg::res_t res;
	logic          cmd_valid, cmd_ready;

	eau_front u_front (
		.clk, .arst_n, .in_ch, .cfg, .cmd, .cmd_valid, .cmd_ready
	);

	eau_back u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready,
		.res, .res_valid(out_ch.valid), .res_ready(out_ch.ready)
	);

	assign out_ch.a_out = res.a;
	assign out_ch.b_out = res.b;
	assign out_ch.overflow_out = res.ov;
	assign out_ch.repeat_request = res.rep;
	assign out_ch.status = res.st;

endmodule

// ===== src/eau_front.sv =====
module eau_front (
	input  logic                clk,
	input  logic                arst_n,
	eau_in_if.sink              in_ch,
	eau_cfg_if.sink             cfg,
	output eau_pkg::cmd_t       cmd,
	output logic                cmd_valid,
	input  logic                cmd_ready
);

	logic       installed_q, stop_undef_q, stop_unimpl_q;
	logic [1:0] model_q;
	logic [eau_pkg::QDEPTH-1:0] vld_q;
	logic [eau_pkg::QDEPTH-1:0] vld_d;
	eau_pkg::cmd_t q_q [eau_pkg::QDEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	eau_pkg::cmd_t c;
	logic [7:0] grp;
	logic [3:0] opc;
	logic       ef, push, pop;

	assign cfg.ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			installed_q <= 1'b1;
			model_q <= 2'd2;
			stop_undef_q <= 1'b0;
			stop_unimpl_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (eau_pkg::reg_idx_t'(cfg.index))
				eau_pkg::REG_INSTALLED:   installed_q <= cfg.data[0];
				eau_pkg::REG_MODEL:       model_q <= cfg.data;
				eau_pkg::REG_STOP_UNDEF:  stop_undef_q <= cfg.data[0];
				eau_pkg::REG_STOP_UNIMPL: stop_unimpl_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// classify the instruction
	always_comb begin
		grp = in_ch.instr_word[15:8];
		opc = in_ch.instr_word[7:4];
		ef = model_q[1];
		c.op = eau_pkg::OP_PASS;
		c.sh = (in_ch.instr_word[3:0] == 4'd0) ? 5'd16 : {1'b0, in_ch.instr_word[3:0]};
		c.a = in_ch.a_in;
		c.b = in_ch.b_in;
		c.m = in_ch.mem_word;
		c.ov = in_ch.overflow_in;
		c.st = eau_pkg::ST_OK;
		if (!installed_q) begin
			if (stop_unimpl_q) c.st = eau_pkg::ST_UNIMPL;
		end else if (grp == eau_pkg::GRP_EAU0) begin
			unique case (opc)
				4'd0: if (!ef && stop_undef_q) c.st = eau_pkg::ST_UNDEF;
				4'd1: c.op = eau_pkg::OP_ASL;
				4'd2: c.op = eau_pkg::OP_LSL;
				4'd3: begin
					if (ef) c.op = eau_pkg::OP_TIMER;
					else if (stop_undef_q) c.st = eau_pkg::ST_UNDEF;
					else if (model_q == 2'd1) c.op = eau_pkg::OP_MPY;
				end
				4'd4: c.op = eau_pkg::OP_RRL;
				4'd8: c.op = eau_pkg::OP_MPY;
				default: if (stop_unimpl_q) c.st = eau_pkg::ST_UNIMPL;
			endcase
		end else if (grp == eau_pkg::GRP_DIV) begin
			c.op = eau_pkg::OP_DIV;
		end else if (grp == eau_pkg::GRP_EAU2) begin
			unique case (opc)
				4'd1: c.op = eau_pkg::OP_ASR;
				4'd2: c.op = eau_pkg::OP_LSR;
				4'd4: c.op = eau_pkg::OP_RRR;
				default: if (stop_undef_q) c.st = eau_pkg::ST_UNDEF;
			endcase
		end else begin
			c.st = eau_pkg::ST_NOTHERE;
		end
	end

	// two-entry queue toward the back
	assign in_ch.ready = ~vld_q[wr_ptr_q];
	assign push = in_ch.valid & in_ch.ready;
	assign cmd_valid = vld_q[rd_ptr_q];
	assign pop = cmd_valid & cmd_ready;
	assign cmd = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) q_q[wr_ptr_q] <= c;
	end

	// mark the written slot full and the read slot empty
	always_comb begin
		vld_d = vld_q;
		if (push) vld_d[wr_ptr_q] = 1'b1;
		if (pop) vld_d[rd_ptr_q] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			vld_q <= vld_d;
			wr_ptr_q <= wr_ptr_q ^ push;
			rd_ptr_q <= rd_ptr_q ^ pop;
		end
	end

	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q == 2'b00 || vld_q == 2'b11) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with occupancy");
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q == 2'b11) |-> !push)
		else $error("push into full queue");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push && vld_q != 2'b11 |=> !cmd_valid)
		else $error("queue not drained");

endmodule

// ===== src/eau_back.sv =====
module eau_back (
	input  logic          clk,
	input  logic          arst_n,
	input  eau_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	output eau_pkg::res_t res,
	output logic          res_valid,
	input  logic          res_ready
);

	localparam int NS = eau_pkg::DIV_STEPS + 3;

	// stage arrays: index 0 input stage, last is output
	logic          vld_s [NS];
	eau_pkg::res_t r_s   [NS];
	logic          div_s [NS];
	logic          mpy_s [NS];
	logic [15:0]   rem_s [NS];
	logic [15:0]   quo_s [NS];
	logic [15:0]   dv_s  [NS];
	logic          rs_s  [NS];
	logic          qs_s  [NS];
	logic          adv;

	logic [31:0]   d, dres, lost, src, fill;
	logic [15:0]   na, nb, v2;
	logic          nov, rs, qs, divov;
	eau_pkg::res_t r0;
	logic signed [31:0] prod;
	logic [15:0]   qf, rf;
	logic          ovf;

	// whole pipe moves when the output is free
	assign adv = !vld_s[NS-1] || res_ready;
	assign cmd_ready = adv;
	assign res_valid = vld_s[NS-1];
	assign res = r_s[NS-1];

	// shifts, timer, divide setup
	always_comb begin
		d = {cmd.b, cmd.a};
		dres = d;
		nov = cmd.ov;
		na = cmd.a;
		nb = cmd.b;
		lost = 32'hFFFF_FFFF << (6'd31 - {1'b0, cmd.sh});
		src = d[31] ? ~d : d;
		fill = d[31] ? 32'hFFFF_FFFF : 32'h0;
		r0.rep = 1'b0;
		unique case (cmd.op)
			eau_pkg::OP_ASL: begin
				nov = |(src & lost);
				dres = {d[31], 31'((d << cmd.sh))};
			end
			eau_pkg::OP_LSL: dres = d << cmd.sh;
			eau_pkg::OP_RRL: dres = (d << cmd.sh) | (d >> (6'd32 - {1'b0, cmd.sh}));
			eau_pkg::OP_ASR: begin
				nov = 1'b0;
				dres = (d >> cmd.sh) | (fill << (6'd32 - {1'b0, cmd.sh}));
			end
			eau_pkg::OP_LSR: dres = d >> cmd.sh;
			eau_pkg::OP_RRR: dres = (d >> cmd.sh) | (d << (6'd32 - {1'b0, cmd.sh}));
			eau_pkg::OP_TIMER: begin
				dres[31:16] = cmd.b + 16'd1;
				r0.rep = (dres[31:16] != 16'd0);
			end
			default: ;
		endcase
		rs = cmd.b[15];
		qs = rs ^ cmd.m[15];
		if (rs) begin
			na = 16'(-cmd.a);
			nb = ~cmd.b + {15'd0, (na == 16'd0)};
		end
		v2 = cmd.m[15] ? 16'(-cmd.m) : cmd.m;
		divov = (nb >= v2);
		if (cmd.op == eau_pkg::OP_DIV) begin
			dres = {nb, na};
			nov = divov ? 1'b1 : 1'b0;
		end
		r0.a = dres[15:0];
		r0.b = dres[31:16];
		r0.ov = nov;
		r0.st = cmd.st;
	end

	// stage 0: capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (adv) vld_s[0] <= cmd_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			r_s[0] <= r0;
			div_s[0] <= (cmd.op == eau_pkg::OP_DIV) && !divov;
			mpy_s[0] <= (cmd.op == eau_pkg::OP_MPY);
			rem_s[0] <= nb;
			quo_s[0] <= na;
			dv_s[0] <= (cmd.op == eau_pkg::OP_MPY) ? cmd.m : v2;
			rs_s[0] <= rs;
			qs_s[0] <= qs;
		end
	end

	// stage 1: multiply, then one restoring divide step per stage
	assign prod = $signed(r_s[0].a) * $signed(dv_s[0]);

	for (genvar i = 1; i < NS; i++) begin : g_st
		logic [16:0]   trial;
		logic [16:0]   diff;
		eau_pkg::res_t r_d;
		logic [15:0]   rem_d;
		logic [15:0]   quo_d;
		always_comb begin
			trial = {rem_s[i-1], quo_s[i-1][15]};
			diff = trial - {1'b0, dv_s[i-1]};
			r_d = r_s[i-1];
			rem_d = rem_s[i-1];
			quo_d = quo_s[i-1];
			if (i == 1 && mpy_s[0]) begin
				r_d.a = prod[15:0];
				r_d.b = prod[31:16];
				r_d.ov = 1'b0;
			end
			if (i <= eau_pkg::DIV_STEPS && div_s[i-1]) begin
				if (!diff[16]) begin
					rem_d = diff[15:0];
					quo_d = {quo_s[i-1][14:0], 1'b1};
				end else begin
					rem_d = trial[15:0];
					quo_d = {quo_s[i-1][14:0], 1'b0};
				end
			end
			if (i == eau_pkg::DIV_STEPS + 1 && div_s[i-1]) begin
				r_d.a = qf;
				r_d.b = rf;
				r_d.ov = ovf;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i] <= 1'b0;
			else if (adv) vld_s[i] <= vld_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				r_s[i] <= r_d;
				div_s[i] <= div_s[i-1];
				mpy_s[i] <= 1'b0;
				rem_s[i] <= rem_d;
				quo_s[i] <= quo_d;
				dv_s[i] <= dv_s[i-1];
				rs_s[i] <= rs_s[i-1];
				qs_s[i] <= qs_s[i-1];
			end
		end
	end

	// signed fix-up of quotient and remainder
	always_comb begin
		qf = quo_s[eau_pkg::DIV_STEPS];
		ovf = 1'b0;
		if (qf != 16'd0) begin
			if (qs_s[eau_pkg::DIV_STEPS]) qf = 16'(-qf);
			ovf = qf[15] ^ qs_s[eau_pkg::DIV_STEPS];
		end
		rf = rs_s[eau_pkg::DIV_STEPS] ? 16'(-rem_s[eau_pkg::DIV_STEPS])
			: rem_s[eau_pkg::DIV_STEPS];
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s[NS-1]))
		else $error("output stage changed during stall");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("empty output blocked input");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && adv |=> vld_s[1])
		else $error("item lost in pipe");

endmodule

// ===== tb/eau_checker.sv =====
module eau_checker (
	input  logic  clk,
	input  logic  arst_n,
	eau_in_if     in_ch,
	eau_out_if    out_ch,
	eau_cfg_if    cfg,
	output int    fail_count,
	output int    result_count
);

	eau_pkg::res_t result_q[$];
	logic        installed;
	logic [1:0]  model;
	logic        stop_undef;
	logic        stop_unimpl;
	int          mismatches;

	function automatic logic [15:0] neg16(logic [15:0] v);
		return 16'(0 - v);
	endfunction

	// compute the register pair, flags and status for one instruction
	function automatic eau_pkg::res_t execute(logic [15:0] ir, logic [15:0] a,
			logic [15:0] b, logic [15:0] m, logic ov);
		eau_pkg::res_t r;
		logic [7:0]  grp;
		logic [3:0]  opc;
		int unsigned sh;
		logic        ef;
		logic        do_mpy;
		logic        set_d;
		logic [31:0] d;
		logic [31:0] lost;
		logic [31:0] src;
		logic [31:0] fill;
		logic [15:0] v2;
		logic [15:0] qs;
		logic        rs;
		logic [31:0] v1;
		logic signed [31:0] p;
		grp = ir[15:8];
		opc = ir[7:4];
		sh = (ir[3:0] != 0) ? ir[3:0] : 16;
		ef = model >= 2;
		d = {b, a};
		do_mpy = 0;
		set_d = 0;
		r.rep = 0;
		r.st = eau_pkg::ST_OK;
		if (!installed) begin
			if (stop_unimpl) r.st = eau_pkg::ST_UNIMPL;
		end else if (grp == eau_pkg::GRP_EAU0) begin
			case (opc)
				4'd0: if (!ef && stop_undef) r.st = eau_pkg::ST_UNDEF;
				4'd1: begin
					lost = 32'hFFFF_FFFF << (31 - sh);
					src = d[31] ? ~d : d;
					ov = (src & lost) != 0;
					d = ((d << sh) & 32'h7FFF_FFFF) | (d & 32'h8000_0000);
					set_d = 1;
				end
				4'd2: begin
					d = d << sh;
					set_d = 1;
				end
				4'd3: begin
					if (ef) begin
						b = b + 16'd1;
						r.rep = b != 0;
					end else if (stop_undef) r.st = eau_pkg::ST_UNDEF;
					else if (model == 1) do_mpy = 1;
				end
				4'd4: begin
					d = (d << sh) | (d >> (32 - sh));
					set_d = 1;
				end
				4'd8: do_mpy = 1;
				default: if (stop_unimpl) r.st = eau_pkg::ST_UNIMPL;
			endcase
		end else if (grp == eau_pkg::GRP_DIV) begin
			rs = b[15];
			qs = {rs, 15'd0};
			v2 = m;
			if (rs) begin
				a = neg16(a);
				b = ~b + (a == 0 ? 16'd1 : 16'd0);
			end
			if (v2[15]) begin
				v2 = neg16(v2);
				qs ^= 16'h8000;
			end
			if (b >= v2) ov = 1;
			else begin
				v1 = {b, a};
				ov = 0;
				a = 16'(v1 / v2);
				b = 16'(v1 % v2);
				if (a != 0) begin
					if (qs[15]) a = neg16(a);
					if (a[15] ^ qs[15]) ov = 1;
				end
				if (rs) b = neg16(b);
			end
		end else if (grp == eau_pkg::GRP_EAU2) begin
			case (opc)
				4'd1: begin
					fill = d[31] ? 32'hFFFF_FFFF : 32'h0;
					ov = 0;
					d = (d >> sh) | (fill << (32 - sh));
					set_d = 1;
				end
				4'd2: begin
					d = d >> sh;
					set_d = 1;
				end
				4'd4: begin
					d = (d >> sh) | (d << (32 - sh));
					set_d = 1;
				end
				default: if (stop_undef) r.st = eau_pkg::ST_UNDEF;
			endcase
		end else r.st = eau_pkg::ST_NOTHERE;
		if (do_mpy) begin
			p = $signed(a) * $signed(m);
			d = p;
			set_d = 1;
			ov = 0;
		end
		if (set_d) begin
			b = d[31:16];
			a = d[15:0];
		end
		r.a = a;
		r.b = b;
		r.ov = ov;
		return r;
	endfunction

	// track config writes, predict on input beats, compare on output beats
	always @(posedge clk or negedge arst_n) begin
		eau_pkg::res_t exp_r;
		if (!arst_n) begin
			installed <= 1;
			model <= 2;
			stop_undef <= 0;
			stop_unimpl <= 0;
			result_q.delete();
			fail_count <= 0;
			result_count <= 0;
			mismatches = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (eau_pkg::reg_idx_t'(cfg.index))
					eau_pkg::REG_INSTALLED:   installed <= cfg.data[0];
					eau_pkg::REG_MODEL:       model <= cfg.data;
					eau_pkg::REG_STOP_UNDEF:  stop_undef <= cfg.data[0];
					eau_pkg::REG_STOP_UNIMPL: stop_unimpl <= cfg.data[0];
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				result_q.push_back(execute(in_ch.instr_word, in_ch.a_in, in_ch.b_in,
					in_ch.mem_word, in_ch.overflow_in));
			if (out_ch.valid && out_ch.ready) begin
				result_count <= result_count + 1;
				if (result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat a=%h b=%h",
						out_ch.a_out, out_ch.b_out);
				end else begin
					exp_r = result_q.pop_front();
					if (out_ch.a_out !== exp_r.a || out_ch.b_out !== exp_r.b ||
							out_ch.overflow_out !== exp_r.ov ||
							out_ch.repeat_request !== exp_r.rep ||
							out_ch.status !== exp_r.st) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch exp a=%h b=%h ov=%b rep=%b st=%0d",
								" got a=%h b=%h ov=%b rep=%b st=%0d"},
								exp_r.a, exp_r.b, exp_r.ov, exp_r.rep, exp_r.st,
								out_ch.a_out, out_ch.b_out, out_ch.overflow_out,
								out_ch.repeat_request, out_ch.status);
					end
				end
			end
			fail_count <= mismatches;
		end
	end

	function automatic int pending();
		return result_q.size();
	endfunction

endmodule

// ===== tb/extended_arithmetic_unit_tb.sv =====
module extended_arithmetic_unit_tb;

	localparam int LATENCY = 20;
	localparam int WATCHDOG = 2000;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count;
	int   result_count;
	int   in_idle;
	int   out_idle;
	int   quiet;
	int   sent;
	bit   timed_out;

	eau_in_if  in_ch();
	eau_out_if out_ch();
	eau_cfg_if cfg();

	extended_arithmetic_unit u_dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg),
		.out_ch(out_ch));

	eau_checker u_chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
		.fail_count(fail_count), .result_count(result_count));

	always #2 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.instr_word = 0;
		in_ch.a_in = 0;
		in_ch.b_in = 0;
		in_ch.mem_word = 0;
		in_ch.overflow_in = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		out_ch.ready = 0;
	end

	// stall the result side at the current rate
	always @(posedge clk)
		out_ch.ready <= ($urandom_range(99) >= out_idle);

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg.valid && cfg.ready) || !arst_n)
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("timeout after %0d idle cycles", quiet);
			$display("FAIL extended_arithmetic_unit");
			$finish;
		end
	end

	// send one instruction beat, holding valid across back-to-back beats
	task automatic send(logic [15:0] ir, logic [15:0] a, logic [15:0] b, logic [15:0] m,
			logic ov);
		while ($urandom_range(99) < in_idle) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.instr_word <= ir;
		in_ch.a_in <= a;
		in_ch.b_in <= b;
		in_ch.mem_word <= m;
		in_ch.overflow_in <= ov;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		@(posedge clk);
		while (u_chk.pending() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(eau_pkg::reg_idx_t idx, logic [1:0] val);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	task automatic set_config(logic inst, logic [1:0] mdl, logic su, logic sm);
		write_reg(eau_pkg::REG_INSTALLED, {1'b0, inst});
		write_reg(eau_pkg::REG_MODEL, mdl);
		write_reg(eau_pkg::REG_STOP_UNDEF, {1'b0, su});
		write_reg(eau_pkg::REG_STOP_UNIMPL, {1'b0, sm});
	endtask

	// mostly valid codes with random counts, some other groups
	function automatic logic [15:0] rand_instr();
		logic [7:0] grp;
		logic [3:0] opc;
		int k;
		k = $urandom_range(99);
		if (k < 35) grp = eau_pkg::GRP_EAU0;
		else if (k < 60) grp = eau_pkg::GRP_DIV;
		else if (k < 90) grp = eau_pkg::GRP_EAU2;
		else grp = 8'($urandom_range(255));
		k = $urandom_range(9);
		opc = (k < 7) ? 4'($urandom_range(4)) : ((k < 8) ? 4'd8 : 4'($urandom_range(15)));
		return {grp, opc, 4'($urandom_range(15))};
	endfunction

	function automatic logic [15:0] rand_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'($urandom_range(15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] neg16c(logic [15:0] v);
		return 16'(0 - v);
	endfunction

	task automatic random_phase(int n);
		logic [15:0] ir;
		logic [15:0] b;
		logic [15:0] m;
		for (int i = 0; i < n; i++) begin
			ir = rand_instr();
			m = rand_word();
			b = rand_word();
			// keep many divides in range so quotients are formed
			if (ir[15:8] == eau_pkg::GRP_DIV && $urandom_range(1) == 1 && m != 0)
				b = 16'($urandom_range((m[15] ? neg16c(m) : m) - 1));
			send(ir, rand_word(), b, m, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		int settings[7][4];
		sent = 0;
		timed_out = 0;
		in_idle = 0;
		out_idle = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every code and the edge cases at reset config
		for (int op = 0; op < 5; op++)
			send({eau_pkg::GRP_EAU0, 4'(op), 4'd0}, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b1);
		send({eau_pkg::GRP_EAU0, 4'd8, 4'd1}, 16'h8000, 16'hFFFF, 16'h8000, 1'b1);
		send({eau_pkg::GRP_EAU0, 4'd8, 4'd1}, 16'h7FFF, 16'h0000, 16'h7FFF, 1'b1);
		send({eau_pkg::GRP_EAU0, 4'd9, 4'd1}, 16'h1234, 16'h5678, 16'h0, 1'b1);
		send({eau_pkg::GRP_EAU0, 4'd3, 4'd0}, 16'h0, 16'hFFFF, 16'h0, 1'b0);
		send({eau_pkg::GRP_EAU0, 4'd1, 4'd1}, 16'h0, 16'h4000, 16'h0, 1'b0);
		send({eau_pkg::GRP_EAU0, 4'd1, 4'd15}, 16'hFFFF, 16'hFFFF, 16'h0, 1'b0);
		send({eau_pkg::GRP_DIV, 8'h00}, 16'h0001, 16'h0000, 16'h0000, 1'b0);
		send({eau_pkg::GRP_DIV, 8'h00}, 16'h0000, 16'h8000, 16'h8000, 1'b0);
		send({eau_pkg::GRP_DIV, 8'h00}, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send({eau_pkg::GRP_DIV, 8'h00}, 16'h0000, 16'h4000, 16'h8001, 1'b0);
		send({eau_pkg::GRP_DIV, 8'h00}, 16'h8000, 16'h0000, 16'h0001, 1'b1);
		send({eau_pkg::GRP_DIV, 8'h00}, 16'h0007, 16'h0000, 16'hFFFE, 1'b1);
		for (int op = 0; op < 6; op++)
			send({eau_pkg::GRP_EAU2, 4'(op), 4'd0}, 16'h0001, 16'h8000, 16'h0, 1'b1);
		send({8'hFF, 8'hFF}, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b1);
		drain();

		// config sweep including every model and stop option
		settings = '{'{1, 2, 0, 0}, '{1, 1, 1, 1}, '{1, 0, 0, 1}, '{1, 3, 1, 0},
			'{0, 1, 0, 1}, '{0, 0, 1, 0}, '{1, 1, 0, 0}};
		for (int s = 0; s < 7; s++) begin
			set_config(1'(settings[s][0]), 2'(settings[s][1]), 1'(settings[s][2]),
				1'(settings[s][3]));
			in_idle = (s < 2) ? 27 : ((s < 4) ? 68 : 0);
			out_idle = (s < 2) ? 68 : ((s < 4) ? 27 : 0);
			random_phase(s == 0 ? 700 : 190);
			drain();
		end
		set_config(1'b1, 2'd2, 1'b0, 1'b0);
		in_idle = 0;
		out_idle = 0;
		random_phase(50);
		drain();

		$display("sent %0d instructions, %0d results checked across 7 configurations",
			sent, result_count);
		$display("covered shifts, rotates, multiply, divide, timer, diag and stop codes");
		if (fail_count == 0 && u_chk.pending() == 0)
			$display("PASS extended_arithmetic_unit");
		else
			$display("FAIL extended_arithmetic_unit");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/eau_pkg.sv
src/eau_if.sv
src/eau_front.sv
src/eau_back.sv
src/extended_arithmetic_unit.sv
tb/eau_checker.sv
tb/extended_arithmetic_unit_tb.sv
